// ----- hw/rtl/gblf_pkg.sv -----
`default_nettype none

package gblf_pkg;

    // Field widths.
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 7;
    localparam int IDX_W      = 6;
    localparam int LEVEL_W    = 5;
    localparam int MB_W       = 8;
    localparam int CCOUNT_W   = 2;
    localparam int CFG_W      = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int DATA_IN_W  = 32;
    localparam int DATA_OUT_W = 32;

    // Blend divider: the quotient always fits one channel.
    localparam int DIVIDEND_W = 21;
    localparam int DIVISOR_W  = 13;
    localparam int QUO_W      = CHAN_W;

    localparam logic [LEVEL_W-1:0]   LEVEL_MIN = 5'd4;
    localparam logic [LEVEL_W-1:0]   LEVEL_MAX = 5'd20;
    localparam logic [DIVISOR_W-1:0] SCALE_DIV = 13'd5100;

    // Division by 5100 as a multiplication by ceil(2^34 / 5100) and a shift,
    // exact for every dividend below 2^21.
    localparam int                 SCALE_IN_W   = LEVEL_W + CHAN_W + MB_W;
    localparam int                 RECIP_W      = 22;
    localparam int                 SCALE_PROD_W = SCALE_IN_W + RECIP_W;
    localparam int                 SCALE_SHIFT  = 34;
    localparam logic [RECIP_W-1:0] SCALE_RECIP  = 22'd3368602;

    localparam int MAX_PIXELS_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COLOR_FIRST    = 3'd0,
        REG_COLOR_SECOND   = 3'd1,
        REG_COLOR_THIRD    = 3'd2,
        REG_COLOR_COUNT    = 3'd3,
        REG_PIXEL_COUNT    = 3'd4,
        REG_MAX_BRIGHTNESS = 3'd5,
        REG_INTERVAL_MS    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COLOR_W-1:0]    color_first;
        logic [COLOR_W-1:0]    color_second;
        logic [COLOR_W-1:0]    color_third;
        logic [CCOUNT_W-1:0]   color_count;
        logic [PIX_W-1:0]      pixel_count;
        logic [MB_W-1:0]       max_brightness;
        logic [INTERVAL_W-1:0] interval_ms;
    } cfg_t;

    // One frame to render: the brightness level it uses and its pixel count.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PIX_W-1:0]   count;
    } frame_cmd_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gblf_front.sv -----
`default_nettype none

module gblf_front
    import gblf_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_IN_W-1:0] s_tdata,
    input  wire logic                 queue_full,
    output logic                      push,
    output frame_cmd_t                push_cmd
);

    localparam logic [PIX_W-1:0] MAX_N =
        (MAX_PIXELS > (2 ** PIX_W - 1)) ? {PIX_W{1'b1}} : PIX_W'(MAX_PIXELS);

    logic [TIME_W-1:0]  last_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               rising_reg;
    logic [TIME_W-1:0]  elapsed;
    logic               accept;
    logic               frame_due;

    assign s_tready  = !queue_full;
    assign accept    = s_tvalid && s_tready;
    assign elapsed   = s_tdata[TIME_W-1:0] - last_reg;
    assign frame_due = elapsed >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.interval_ms};
    assign push      = accept && frame_due;

    assign push_cmd.level = level_reg;
    assign push_cmd.count = (cfg.pixel_count > MAX_N) ? MAX_N : cfg.pixel_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '0;
            level_reg  <= LEVEL_MIN;
            rising_reg <= 1'b1;
        end
        else if (push)
        begin
            last_reg <= s_tdata[TIME_W-1:0];
            // Triangle wave between the two level limits.
            if (rising_reg)
            begin
                if (level_reg + 1'b1 >= LEVEL_MAX)
                begin
                    level_reg  <= LEVEL_MAX;
                    rising_reg <= 1'b0;
                end
                else
                begin
                    level_reg <= level_reg + 1'b1;
                end
            end
            else
            begin
                if (level_reg - 1'b1 <= LEVEL_MIN)
                begin
                    level_reg  <= LEVEL_MIN;
                    rising_reg <= 1'b1;
                end
                else
                begin
                    level_reg <= level_reg - 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gblf_queue.sv -----
`default_nettype none

module gblf_queue
    import gblf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire frame_cmd_t push_data,
    input  wire logic       pop,
    output frame_cmd_t      pop_data,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_cmd_t        entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gblf_div.sv -----
`default_nettype none

// Restoring divider producing one quotient bit per cycle. The caller
// guarantees that the quotient fits QUO_W bits.
module gblf_div
    import gblf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int SH_W  = DIVISOR_W + QUO_W - 1;
    localparam int CNT_W = $clog2(QUO_W);

    logic [DIVIDEND_W-1:0] rem_reg;
    logic [SH_W-1:0]       dsh_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  fits;

    assign fits         = rem_reg >= DIVIDEND_W'(dsh_reg);
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dsh_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            rem_reg  <= req.dividend;
            dsh_reg  <= {req.divisor, {(QUO_W-1){1'b0}}};
            quo_reg  <= '0;
            cnt_reg  <= CNT_W'(QUO_W - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - DIVIDEND_W'(dsh_reg);
            end
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gblf_back.sv -----
`default_nettype none

module gblf_back
    import gblf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        queue_empty,
    input  wire frame_cmd_t  queue_cmd,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [DATA_OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MIX,
        ST_MIX_WAIT,
        ST_LEVEL,
        ST_BRIGHT,
        ST_SCALE,
        ST_EMIT
    } state_t;

    localparam int MIX_W  = 2 * CHAN_W;
    localparam int PROD_W = LEVEL_W + CHAN_W;
    localparam logic [1:0] CH_BLUE = 2'd2;

    state_t             state_reg;
    logic [PIX_W-1:0]   j_reg;
    logic [PIX_W-1:0]   n_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [COLOR_W-1:0] a_reg;
    logic [COLOR_W-1:0] b_reg;
    logic [PIX_W-1:0]   num_reg;
    logic [PIX_W-1:0]   den_reg;
    logic [1:0]         ch_reg;
    logic [CHAN_W-1:0]  c_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SCALE_IN_W-1:0] bright_reg;
    logic [CHAN_W-1:0]  red_reg;
    logic [CHAN_W-1:0]  green_reg;
    logic [CHAN_W-1:0]  blue_reg;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [CHAN_W-1:0]  out_red_reg;
    logic [CHAN_W-1:0]  out_green_reg;
    logic [CHAN_W-1:0]  out_blue_reg;
    logic               out_last_reg;

    logic [COLOR_W-1:0] sel_a;
    logic [COLOR_W-1:0] sel_b;
    logic [PIX_W-1:0]   sel_num;
    logic [PIX_W-1:0]   sel_den;
    logic [PIX_W-1:0]   half;
    logic [CHAN_W-1:0]  a_ch;
    logic [CHAN_W-1:0]  b_ch;
    logic [MIX_W-1:0]   mix;
    logic [CHAN_W-1:0]  scaled;
    logic               out_free;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    function automatic logic [CHAN_W-1:0] chan_of(
        input logic [COLOR_W-1:0] color,
        input logic [1:0]         ch
    );
        unique case (ch)
            2'd0:    return color[23:16];
            2'd1:    return color[15:8];
            default: return color[7:0];
        endcase
    endfunction

    // Segment and weights for the current pixel.
    always_comb
    begin
        half    = n_reg >> 1;
        sel_a   = cfg.color_first;
        sel_b   = cfg.color_first;
        sel_num = '0;
        sel_den = PIX_W'(1);
        unique case (cfg.color_count)
            2'd2:
            begin
                sel_b   = cfg.color_second;
                sel_num = j_reg;
                sel_den = n_reg - 1'b1;
            end
            2'd3:
            begin
                if (j_reg < half)
                begin
                    sel_b   = cfg.color_second;
                    sel_num = j_reg;
                    sel_den = half - 1'b1;
                end
                else
                begin
                    sel_a   = cfg.color_second;
                    sel_b   = cfg.color_third;
                    sel_num = j_reg - half;
                    sel_den = half;
                end
            end
            default:
            begin
                sel_b = cfg.color_first;
            end
        endcase
        // A zero-length segment keeps its starting colour.
        if (sel_den == '0)
        begin
            sel_num = '0;
            sel_den = PIX_W'(1);
        end
    end

    assign a_ch = chan_of(a_reg, ch_reg);
    assign b_ch = chan_of(b_reg, ch_reg);
    assign mix  = MIX_W'(a_ch) * MIX_W'(den_reg - num_reg)
                + MIX_W'(b_ch) * MIX_W'(num_reg);

    // Truncating division of the scaled channel by 5100.
    assign scaled = CHAN_W'((SCALE_PROD_W'(bright_reg) * SCALE_PROD_W'(SCALE_RECIP))
                            >> SCALE_SHIFT);

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            ST_MIX:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(mix);
                div_req.divisor  = DIVISOR_W'(den_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    gblf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign pop      = (state_reg == ST_IDLE) && !queue_empty;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(DATA_OUT_W - IDX_W - 3 * CHAN_W){1'b0}},
                       out_blue_reg, out_green_reg, out_red_reg, out_index_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            n_reg         <= '0;
            level_reg     <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            ch_reg        <= '0;
            c_reg         <= '0;
            prod_reg      <= '0;
            bright_reg    <= '0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_red_reg   <= '0;
            out_green_reg <= '0;
            out_blue_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // A new pixel may replace the one leaving in the same cycle.
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        n_reg     <= queue_cmd.count;
                        level_reg <= queue_cmd.level;
                        j_reg     <= '0;
                        // An empty strip still consumes its frame.
                        if (queue_cmd.count != '0)
                        begin
                            state_reg <= ST_SETUP;
                        end
                    end
                end
                ST_SETUP:
                begin
                    a_reg     <= sel_a;
                    b_reg     <= sel_b;
                    num_reg   <= sel_num;
                    den_reg   <= sel_den;
                    ch_reg    <= '0;
                    state_reg <= ST_MIX;
                end
                ST_MIX:
                begin
                    state_reg <= ST_MIX_WAIT;
                end
                ST_MIX_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        c_reg     <= div_rsp.quotient;
                        state_reg <= ST_LEVEL;
                    end
                end
                ST_LEVEL:
                begin
                    prod_reg  <= PROD_W'(c_reg) * PROD_W'(level_reg);
                    state_reg <= ST_BRIGHT;
                end
                ST_BRIGHT:
                begin
                    bright_reg <= SCALE_IN_W'(prod_reg) * SCALE_IN_W'(cfg.max_brightness);
                    state_reg  <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    unique case (ch_reg)
                        2'd0:    red_reg   <= scaled;
                        2'd1:    green_reg <= scaled;
                        default: blue_reg  <= scaled;
                    endcase
                    if (ch_reg == CH_BLUE)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= ST_MIX;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_index_reg <= j_reg[IDX_W-1:0];
                        out_red_reg   <= red_reg;
                        out_green_reg <= green_reg;
                        out_blue_reg  <= blue_reg;
                        out_last_reg  <= (j_reg + 1'b1 == n_reg);
                        if (j_reg + 1'b1 == n_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_SETUP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gradient_breathing_led_frame.sv -----
// A timestamp transfer is taken in the cycle it is offered whenever the frame
// queue has room. With the back end idle, each pixel of a frame is set up, then
// blended, levelled and scaled per channel before it is presented at the output.
// The back end computes one pixel at a time, its pace set by the
// eight-step blend divider run once per channel; a slow sink stalls only on a full output.
// Reset (rst_n, asynchronous, active low) restores the default configuration,
// clears the frame time, sets the level to 4 rising and empties queue and output.
`default_nettype none

module gradient_breathing_led_frame
    import gblf_pkg::*;
#(
    parameter int MAX_PIXELS  = MAX_PIXELS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // Timestamp stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [DATA_IN_W-1:0]   s_tdata,   // [31:0] now_ms

    // Pixel stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [DATA_OUT_W-1:0]       m_tdata,   // [5:0] pixel_index, [13:6] red,
                                                   // [21:14] green, [29:22] blue, rest zero
    output logic                        m_tlast,   // frame_last

    // Configuration writes.
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    // The design splits into a front end that decides, for every timestamp
    // transfer, whether a new frame is due, and a back end that renders the
    // pixels of each frame. A short queue of frame commands sits between them,
    // so timestamps keep being taken while a frame is still being drawn.

    cfg_t       cfg_reg;
    logic       push;
    frame_cmd_t push_cmd;
    logic       pop;
    frame_cmd_t pop_cmd;
    logic       queue_full;
    logic       queue_empty;

    // Configuration register file. Writes to unused indexes are ignored. The
    // registers are to be changed by the user only while the block is idle; the
    // block itself does not enforce this. Both ends read them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_first    <= 24'hFF0000;
            cfg_reg.color_second   <= 24'h0000FF;
            cfg_reg.color_third    <= 24'h00FF00;
            cfg_reg.color_count    <= 2'd1;
            cfg_reg.pixel_count    <= 7'd64;
            cfg_reg.max_brightness <= 8'd255;
            cfg_reg.interval_ms    <= 16'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLOR_FIRST:    cfg_reg.color_first    <= cfg_data[COLOR_W-1:0];
                REG_COLOR_SECOND:   cfg_reg.color_second   <= cfg_data[COLOR_W-1:0];
                REG_COLOR_THIRD:    cfg_reg.color_third    <= cfg_data[COLOR_W-1:0];
                REG_COLOR_COUNT:    cfg_reg.color_count    <= cfg_data[CCOUNT_W-1:0];
                REG_PIXEL_COUNT:    cfg_reg.pixel_count    <= cfg_data[PIX_W-1:0];
                REG_MAX_BRIGHTNESS: cfg_reg.max_brightness <= cfg_data[MB_W-1:0];
                REG_INTERVAL_MS:    cfg_reg.interval_ms    <= cfg_data[INTERVAL_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Front end: wrapping elapsed-time check, frame time capture and the
    // triangle-wave brightness level. Each due frame becomes one command
    // holding the level it is drawn at and its clamped pixel count.
    gblf_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    gblf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Back end: per pixel, picks the gradient segment, blends each channel
    // and scales it by level * max_brightness / 5100, both divisions truncating.
    // An output register holds one finished pixel while the next is computed.
    gblf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .queue_cmd   (pop_cmd),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
